@@ src/bba_pkg.sv @@
// Shared types, constants and helper functions for the bitmap block allocator.
package bba_pkg;

  localparam int BITMAP_BYTES = 1024;
  localparam int ADDR_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int BLK_W        = 13;
  localparam int TOTAL_W      = 14;
  localparam int BYTE_W       = 8;
  localparam int BIT_W        = 3;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(BITMAP_BYTES - 1);
  localparam logic [BYTE_W-1:0]  BYTE_FULL   = 8'hFF;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 14'd8192;
  localparam logic [APB_AW-1:0]  REG_TOTAL_BLOCKS = 3'd0;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                mode;
    logic [BLK_W-1:0]    block_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [BLK_W-1:0]    block_out;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
  } ram_req_t;

  // Position of the lowest clear bit of a byte that is not full.
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [BYTE_W-1:0] b);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!b[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

@@ src/bitmap_block_allocator.sv @@
// Top level of the first-fit free-block bitmap allocator.
//
// The block keeps one usage bit per disk block in a 1024 x 8 bitmap RAM
// (bit n%8 of byte n/8 is set while block n is in use). After reset a
// clearing pass writes every byte to zero, one byte per cycle; in_ready
// stays low until it ends, while the configuration port works as usual.
// An allocate request scans the bitmap from byte 0 upward through the single
// RAM read port, one byte per cycle with a registered read, takes the
// lowest clear bit of the first byte that is not full, sets it and returns its
// block number; the total_blocks register is not consulted. A free request
// is a read-modify-write of one byte; a block at or above total_blocks is
// reported as ignored. One request is in flight at a time: in_ready is
// high only while the sequencer is idle. Each result lands in an output
// register, so the next request is taken while an earlier result still
// waits for out_ready; a finished result only holds the sequencer when
// that register is still occupied.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  // APB-style configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_AW-1:0]  cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               cfg_wr;
  logic               res_valid;
  logic               res_ready;
  out_item_t          res;
  ram_req_t           ram_req;
  logic [BYTE_W-1:0]  ram_rdata;

  // Config write completes on the access phase; pready is tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_TOTAL_BLOCKS) ? APB_DW'(total_r) : '0;

  always_comb begin
    total_nxt = total_r;
    if (cfg_wr && cfg_paddr == REG_TOTAL_BLOCKS) total_nxt = cfg_pwdata[TOTAL_W-1:0];
  end

  // Output register: loads when empty or being drained in the same cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= TOTAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .total_blocks (total_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  bba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ src/bba_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/bba_ctrl.sv @@
// Sequencer: clearing pass, first-fit byte scan and free read-modify-write.
module bba_ctrl import bba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  input  logic [TOTAL_W-1:0]  total_blocks,
  output logic                res_valid,
  input  logic                res_ready,
  output out_item_t           res,
  output ram_req_t            ram_req,
  input  logic [BYTE_W-1:0]   ram_rdata
);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]  chk_addr_r, chk_addr_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  out_item_t          res_r, res_nxt;

  logic               accept;
  logic               found;
  logic               scan_end;
  logic               out_of_range;
  logic [BIT_W-1:0]   free_pos;
  logic [BIT_W-1:0]   blk_bit;

  assign accept   = in_valid && in_ready;
  assign found    = chk_vld_r && (ram_rdata != BYTE_FULL);
  assign scan_end = chk_vld_r && (chk_addr_r == LAST_ADDR) && !found;
  assign free_pos = lowest_clear(ram_rdata);
  assign blk_bit  = blk_r[BIT_W-1:0];
  assign out_of_range = ({1'b0, in_data.block_number} >= total_blocks) ||
                        ((32'(in_data.block_number) >> BIT_W) >= 32'(BITMAP_BYTES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (idx_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_ALLOC) state_nxt = S_SCAN;
          else if (out_of_range)          state_nxt = S_DONE;
          else                            state_nxt = S_FWR;
        end
      end
      S_SCAN:  if (found || scan_end) state_nxt = S_DONE;
      S_FWR:   state_nxt = S_DONE;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = chk_addr_r;
    ram_req.wdata = ram_rdata | (BYTE_W'(1) << free_pos);
    ram_req.raddr = idx_r;
    case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = '0;
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        ram_req.raddr = ADDR_W'(32'(in_data.block_number) >> BIT_W);
      end
      S_SCAN:  ram_req.we = found;
      S_FWR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(32'(blk_r) >> BIT_W);
        ram_req.wdata = ram_rdata & ~(BYTE_W'(1) << blk_bit);
      end
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    blk_nxt        = blk_r;
    res_nxt        = res_r;
    case (state_r)
      S_CLEAR: idx_nxt = idx_r + 1'b1;
      S_IDLE: begin
        idx_nxt        = '0;
        issue_done_nxt = 1'b0;
        blk_nxt        = in_data.block_number;
        res_nxt.status    = ST_IGNORED;
        res_nxt.block_out = '0;
      end
      S_SCAN: begin
        // one byte read issued per cycle, checked the cycle after
        if (!issue_done_r) begin
          chk_vld_nxt    = 1'b1;
          chk_addr_nxt   = idx_r;
          idx_nxt        = idx_r + 1'b1;
          issue_done_nxt = (idx_r == LAST_ADDR);
        end
        if (found) begin
          res_nxt.status    = ST_ALLOCATED;
          res_nxt.block_out = BLK_W'({chk_addr_r, free_pos});
        end else if (scan_end) begin
          res_nxt.status    = ST_NONE_FREE;
          res_nxt.block_out = '0;
        end
      end
      S_FWR: begin
        res_nxt.status    = ST_FREED;
        res_nxt.block_out = blk_r;
      end
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    blk_r      <= blk_nxt;
    res_r      <= res_nxt;
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_req.we)
    else $error("bitmap written while idle");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && idx_r == LAST_ADDR) |=> (state_r == S_IDLE))
    else $error("clearing pass did not end at the last byte");

  a_alloc_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |-> $onehot(ram_req.wdata ^ ram_rdata))
    else $error("allocation changed other than one bit");

  a_free_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWR) |-> ($countones(ram_req.wdata ^ ram_rdata) <= 1))
    else $error("free changed more than one bit");

endmodule
